### src/fiws_pkg.sv
package fiws_pkg;

  // Number of intervals held in the window.
  localparam int WINDOW = 120;
  // Width of a cell position or ring slot.
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  // Width of a count that can hold WINDOW itself.
  localparam int CNT_W = $clog2(WINDOW + 1);

  localparam int TIME_W = 63;
  localparam int IVAL_W = 48;
  localparam int MED_W = IVAL_W + 1;
  localparam int COMMIT_W = 32;
  localparam int RECENT_W = 32;
  localparam int SCOUNT_W = 7;

  localparam logic [RECENT_W-1:0] RECENT_RESET = RECENT_W'(2000000000);

  // The 95th percentile position is ceil(n*95/100)-1. The division by 100 is
  // a multiplication by 5243 / 2^19, which is exact over the whole count range.
  localparam int P95_NUM = 95;
  localparam int P95_BIAS = 99;
  localparam int P95_RECIP = 5243;
  localparam int P95_SHIFT = 19;
  localparam int P95_W = CNT_W + 7;
  localparam int P95_PROD_W = P95_W + 13;

  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] now_ns;
  } sample_t;

  typedef struct packed {
    logic [COMMIT_W-1:0] commit_count;
    logic                has_last;
    logic [TIME_W-1:0]   last_age_ns;
    logic [SCOUNT_W-1:0] sample_count;
    logic                stats_valid;
    logic [MED_W-1:0]    median_twice_ns;
    logic [IVAL_W-1:0]   p95_ns;
    logic [IVAL_W-1:0]   max_ns;
  } report_t;

  // Broadcast from the controller to every cell of the sorted chain.
  typedef struct packed {
    logic              evict;
    logic              insert;
    logic [IVAL_W-1:0] ival;
    logic [IVAL_W-1:0] vev;
    logic [CNT_W-1:0]  occ;
    logic [SLOT_W-1:0] med_lo;
    logic [SLOT_W-1:0] med_hi;
    logic [SLOT_W-1:0] p95;
    logic [SLOT_W-1:0] mx;
  } cell_ctl_t;

  // Values picked out of the chain at the statistic positions.
  typedef struct packed {
    logic [IVAL_W-1:0] lo;
    logic [IVAL_W-1:0] hi;
    logic [IVAL_W-1:0] p95;
    logic [IVAL_W-1:0] mx;
  } cell_tap_t;

  function automatic logic [SLOT_W-1:0] p95_index(input logic [CNT_W-1:0] cnt);
    logic [P95_W-1:0]      x;
    logic [P95_PROD_W-1:0] prod;
    logic [P95_PROD_W-1:0] q;
    x = P95_W'(cnt) * P95_W'(P95_NUM) + P95_W'(P95_BIAS);
    prod = P95_PROD_W'(x) * P95_PROD_W'(P95_RECIP);
    q = prod >> P95_SHIFT;
    return SLOT_W'(q - P95_PROD_W'(1));
  endfunction

endpackage

### src/fiws_cell.sv
module fiws_cell
  import fiws_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [SLOT_W-1:0] idx,
  input  logic [IVAL_W-1:0] left_val,
  input  logic              left_gt,
  input  logic [IVAL_W-1:0] right_val,
  output logic [IVAL_W-1:0] val,
  output logic              gt,
  output cell_tap_t         tap
);

  logic              vld;
  logic              ge_ev;
  logic [IVAL_W-1:0] val_next;

  // Cells below the occupancy hold sorted values; those above count as infinite.
  assign vld   = CNT_W'(idx) < ctl.occ;
  assign gt    = !vld || (val > ctl.ival);
  assign ge_ev = vld && (val >= ctl.vev);

  always_comb begin
    val_next = val;
    if (ctl.evict && ge_ev) begin
      val_next = right_val;
    end else if (ctl.insert && gt) begin
      val_next = left_gt ? left_val : ctl.ival;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  assign tap.lo  = (idx == ctl.med_lo) ? val : '0;
  assign tap.hi  = (idx == ctl.med_hi) ? val : '0;
  assign tap.p95 = (idx == ctl.p95) ? val : '0;
  assign tap.mx  = (idx == ctl.mx) ? val : '0;

endmodule

### src/fiws_chain.sv
module fiws_chain
  import fiws_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  output cell_tap_t sel
);

  logic [IVAL_W-1:0] vals [WINDOW];
  logic              gts  [WINDOW];
  cell_tap_t         taps [WINDOW];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [IVAL_W-1:0] lv;
    logic              lg;
    logic [IVAL_W-1:0] rv;

    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = vals[i-1];
      assign lg = gts[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign rv = '0;
    end else begin : g_body
      assign rv = vals[i+1];
    end

    fiws_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (SLOT_W'(i)),
      .left_val  (lv),
      .left_gt   (lg),
      .right_val (rv),
      .val       (vals[i]),
      .gt        (gts[i]),
      .tap       (taps[i])
    );
  end

  // Each position matches in at most one cell, so the taps merge by OR.
  always_comb begin
    sel = '0;
    for (int i = 0; i < WINDOW; i++) begin
      sel = sel | taps[i];
    end
  end

endmodule

### src/frame_interval_window_stats_top.sv
// Frame interval window statistics: one report item for every sample item.
// Each accepted item passes the CALC, INS and SEL states before it reaches the report
// register: the evict, insert and select passes through the sorted cell chain.
// The next item is taken as the report loads, which waits while the report side stalls.
// Reset (synchronous, active high) clears counts, last commit time, the ring
// pointer and the recent window register (to 2 s); the window memory is not cleared.
module frame_interval_window_stats_top
  import fiws_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  sample_t             sample,
  output logic                report_valid,
  input  logic                report_stall,
  output report_t             report,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [RECENT_W-1:0] cfg_data
);

  // The block has four phases; each item walks through CALC, INS and SEL. IDLE and
  // SEL both accept, so a new item can enter as soon as the previous report is loaded.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_INS  = 4'b0100,
    ST_SEL  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Architectural state, as seen by the user of the block.
  logic [SLOT_W-1:0]   write_slot;
  logic [CNT_W-1:0]    held_count;
  logic [TIME_W-1:0]   last_commit;
  logic [COMMIT_W-1:0] commits;
  logic [RECENT_W-1:0] recent;

  // The ring of intervals in arrival order. It tells the chain which value is
  // the oldest when the window is full. The read port runs on every cycle.
  logic [IVAL_W-1:0] ring [WINDOW];
  logic [IVAL_W-1:0] ring_rd;

  // The accepted item and the results of the arithmetic phase.
  sample_t           item;
  logic [IVAL_W-1:0] ival;
  logic              store;
  logic [TIME_W-1:0] age;
  logic              has_last;
  logic              stv;

  // Statistic positions, derived from the held count on every cycle.
  logic [SLOT_W-1:0] med_lo;
  logic [SLOT_W-1:0] med_hi;
  logic [SLOT_W-1:0] p95_pos;
  logic [SLOT_W-1:0] max_pos;

  logic              accept;
  logic              out_free;
  logic              later;
  logic [TIME_W-1:0] diff;
  logic              store_now;
  logic              full;
  cell_ctl_t         ctl;
  cell_tap_t         sel;
  report_t           report_next;

  assign cfg_ready = 1'b1;

  assign out_free     = !report_valid || !report_stall;
  assign sample_stall = !((state == ST_IDLE) || ((state == ST_SEL) && out_free));
  assign accept       = sample_valid && !sample_stall;

  // One subtraction serves both the stored interval and the age of the last commit.
  assign later     = (last_commit != '0) && (item.now_ns > last_commit);
  assign diff      = item.now_ns - last_commit;
  assign store_now = item.req_type && later;
  assign full      = held_count == CNT_W'(WINDOW);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: state_next = ST_INS;
      ST_INS:  state_next = ST_SEL;
      ST_SEL: begin
        if (accept) begin
          state_next = ST_CALC;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_slot  <= '0;
      held_count  <= '0;
      last_commit <= '0;
      commits     <= '0;
      recent      <= RECENT_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        recent <= cfg_data;
      end
      if (state == ST_CALC && item.req_type) begin
        last_commit <= item.now_ns;
        if (commits != '1) begin
          commits <= commits + COMMIT_W'(1);
        end
        if (store_now && !full) begin
          held_count <= held_count + CNT_W'(1);
        end
      end
      if (state == ST_INS && store) begin
        write_slot <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= sample;
    end
    if (state == ST_CALC) begin
      store <= store_now;
      ival  <= (diff[TIME_W-1:IVAL_W] != '0) ? '1 : diff[IVAL_W-1:0];
      // A commit makes itself the last commit, so its own age is zero.
      if (item.req_type) begin
        has_last <= item.now_ns != '0;
        age      <= '0;
      end else begin
        has_last <= last_commit != '0;
        age      <= later ? diff : '0;
      end
    end
    if (state == ST_INS) begin
      stv <= has_last && (age <= TIME_W'(recent)) && (held_count != '0);
    end
    med_lo  <= SLOT_W'(CNT_W'(held_count - CNT_W'(1)) >> 1);
    med_hi  <= SLOT_W'(held_count >> 1);
    p95_pos <= p95_index(held_count);
    max_pos <= SLOT_W'(held_count - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (state == ST_INS && store) begin
      ring[write_slot] <= ival;
    end
    ring_rd <= ring[write_slot];
  end

  // During CALC the chain drops the oldest value when the window is full and a new
  // interval is stored, and during INS it puts a stored interval at its sorted place.
  always_comb begin
    ctl        = '0;
    ctl.ival   = ival;
    ctl.vev    = ring_rd;
    ctl.occ    = held_count;
    ctl.med_lo = med_lo;
    ctl.med_hi = med_hi;
    ctl.p95    = p95_pos;
    ctl.mx     = max_pos;
    case (state)
      ST_CALC: begin
        ctl.evict = store_now && full;
        ctl.occ   = CNT_W'(WINDOW);
      end
      ST_INS: begin
        ctl.insert = store;
        ctl.occ    = held_count - CNT_W'(1);
      end
      default: begin
        ctl.evict  = 1'b0;
        ctl.insert = 1'b0;
      end
    endcase
  end

  fiws_chain u_chain (
    .clk (clk),
    .ctl (ctl),
    .sel (sel)
  );

  always_comb begin
    report_next.commit_count    = commits;
    report_next.has_last        = has_last;
    report_next.last_age_ns     = age;
    report_next.sample_count    = SCOUNT_W'(held_count);
    report_next.stats_valid     = stv;
    report_next.median_twice_ns = '0;
    report_next.p95_ns          = '0;
    report_next.max_ns          = '0;
    if (stv) begin
      report_next.median_twice_ns = MED_W'(sel.lo) + MED_W'(sel.hi);
      report_next.p95_ns          = sel.p95;
      report_next.max_ns          = sel.mx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (state == ST_SEL && out_free) begin
      report_valid <= 1'b1;
    end else if (!report_stall) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEL && out_free) begin
      report <= report_next;
    end
  end

endmodule

### src/fiws_checker.sv
module fiws_checker
  import fiws_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_stall,
  input logic    report_valid,
  input logic    report_stall,
  input report_t report
);

  // A stalled report item stays in place.
  a_report_hold: assert property (@(posedge clk) disable iff (rst)
    report_valid && report_stall |=> report_valid && $stable(report))
    else $error("report item changed while stalled");

  // One item is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("second item taken while one is in flight");

  // Valid statistics need a last commit and a non-empty window.
  a_valid_needs_data: assert property (@(posedge clk) disable iff (rst)
    report_valid && report.stats_valid |->
      report.has_last && report.sample_count != '0)
    else $error("statistics valid without data");

  // Invalid statistics read as zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report.stats_valid |->
      report.median_twice_ns == '0 && report.p95_ns == '0 && report.max_ns == '0)
    else $error("statistics not cleared when invalid");

  // The percentile never exceeds the maximum.
  a_p95_le_max: assert property (@(posedge clk) disable iff (rst)
    report_valid && report.stats_valid |-> report.p95_ns <= report.max_ns)
    else $error("95th percentile above maximum");

endmodule

bind frame_interval_window_stats_top fiws_checker u_fiws_checker (.*);

### tb/frame_interval_window_stats_top_tb.sv
`timescale 1ns / 1ps

module frame_interval_window_stats_top_tb;
  import fiws_pkg::*;

  logic                clk;
  logic                rst;
  logic                sample_valid;
  logic                sample_stall;
  sample_t             sample;
  logic                report_valid;
  logic                report_stall;
  report_t             report;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [RECENT_W-1:0] cfg_data;

  frame_interval_window_stats_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // Free-running clock with an 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Our own copy of the pacing state. The ring holds the most recent
  // intervals; entries are only read once they have been written, because
  // the held count never exceeds the number of slots filled so far.
  logic [IVAL_W-1:0]   ring_ns [WINDOW];
  int                  ring_slot;
  int                  ring_held;
  logic [TIME_W-1:0]   prev_commit_ns;
  logic [COMMIT_W-1:0] commit_total;
  logic [RECENT_W-1:0] recent_limit_ns;

  // Reports that have been predicted but not yet seen on the output, oldest first.
  report_t pending_reports [$];
  int      errors;

  // When set, neither side inserts idle cycles, so stretches of back-to-back
  // items are exercised as well as heavily gapped traffic.
  logic steady;

  // Mostly short gaps, with the occasional long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  // Advances the pacing state by one sample item and works out the report
  // that item must produce. The statistics come from a sorted copy of the
  // held intervals: the median as the sum of the two middle values, the 95th
  // percentile at position ceil(n*95/100)-1, and the largest value.
  function automatic report_t pace_predict(input logic commit, input logic [TIME_W-1:0] now);
    report_t           r;
    logic [TIME_W-1:0] gap_ns;
    logic [TIME_W-1:0] age;
    logic [IVAL_W-1:0] ordered [WINDOW];
    logic [IVAL_W-1:0] key;
    logic              has_last;
    logic              valid;
    int                i;
    int                j;
    int                pos;

    if (commit) begin
      // An interval is only recorded when a timed commit precedes this one
      // and time has actually moved forward.
      if (prev_commit_ns != '0 && now > prev_commit_ns) begin
        gap_ns = now - prev_commit_ns;
        if (gap_ns > TIME_W'({IVAL_W{1'b1}})) begin
          gap_ns = TIME_W'({IVAL_W{1'b1}});
        end
        ring_ns[ring_slot] = gap_ns[IVAL_W-1:0];
        ring_slot = (ring_slot + 1) % WINDOW;
        if (ring_held < WINDOW) begin
          ring_held++;
        end
      end
      prev_commit_ns = now;
      if (commit_total != {COMMIT_W{1'b1}}) begin
        commit_total++;
      end
    end

    has_last = (prev_commit_ns != '0);
    age = '0;
    if (has_last && now > prev_commit_ns) begin
      age = now - prev_commit_ns;
    end
    // Time running backward gives an age of zero, which always counts as recent.
    valid = has_last && (age <= TIME_W'(recent_limit_ns)) && (ring_held > 0);

    r = '0;
    r.commit_count = commit_total;
    r.has_last     = has_last;
    r.last_age_ns  = age;
    r.sample_count = SCOUNT_W'(ring_held);
    r.stats_valid  = valid;

    if (valid) begin
      for (i = 0; i < ring_held; i++) begin
        ordered[i] = ring_ns[i];
      end
      for (i = 1; i < ring_held; i++) begin
        key = ordered[i];
        j = i;
        while (j > 0 && ordered[j-1] > key) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = key;
      end
      pos = (ring_held * 95 + 99) / 100 - 1;
      r.median_twice_ns = MED_W'(ordered[(ring_held - 1) / 2]) + MED_W'(ordered[ring_held / 2]);
      r.p95_ns = ordered[pos];
      r.max_ns = ordered[ring_held - 1];
    end
    return r;
  endfunction

  // Presents one sample item at the falling edge and holds it until it is
  // accepted. Valid is left high afterwards, so a following item follows on
  // without a bubble unless a random gap is taken here.
  task automatic push_sample(input logic commit, input logic [TIME_W-1:0] now);
    sample_t item;
    item.req_type = commit;
    item.now_ns   = now;
    @(negedge clk);
    sample_valid <= 1'b1;
    sample       <= item;
    do @(posedge clk); while (sample_stall);
    pending_reports.push_back(pace_predict(commit, now));
    if (!steady && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      sample_valid <= 1'b0;
      repeat (pick_gap() - 1) @(negedge clk);
    end
  endtask

  // Stops sending and waits until every predicted report has come out.
  task automatic drain_reports();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // The register is only written while the block is idle: all reports are in
  // and a few extra cycles have passed to cover the pipeline depth.
  task automatic write_recent_window(input logic [RECENT_W-1:0] value);
    drain_reports();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    recent_limit_ns = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Every accepted report is checked against the oldest prediction.
  always @(posedge clk) begin : report_monitor
    report_t want;
    if (!rst && report_valid && !report_stall) begin
      if (pending_reports.size() == 0) begin
        $error("report item arrived with no sample item outstanding");
        errors++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("commit_count", 64'(want.commit_count), 64'(report.commit_count));
        compare_field("has_last", 64'(want.has_last), 64'(report.has_last));
        compare_field("last_age_ns", 64'(want.last_age_ns), 64'(report.last_age_ns));
        compare_field("sample_count", 64'(want.sample_count), 64'(report.sample_count));
        compare_field("stats_valid", 64'(want.stats_valid), 64'(report.stats_valid));
        compare_field("median_twice_ns", 64'(want.median_twice_ns),
                      64'(report.median_twice_ns));
        compare_field("p95_ns", 64'(want.p95_ns), 64'(report.p95_ns));
        compare_field("max_ns", 64'(want.max_ns), 64'(report.max_ns));
      end
    end
  end

  // Random back-pressure on the report side: mostly flowing, with stalls of
  // mixed length. One assignment per falling edge keeps the stall clean.
  initial begin : report_backpressure
    int unsigned hold_left;
    hold_left = 0;
    report_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (steady || rst) begin
        hold_left = 0;
        report_stall <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        report_stall <= 1'b1;
      end else if ($urandom_range(0, 9) < 2) begin
        hold_left = pick_gap() - 1;
        report_stall <= 1'b1;
      end else begin
        report_stall <= 1'b0;
      end
    end
  end

  // Hand-picked items covering the corner cases of the pacing logic, run
  // under the reset value of the recent window.
  task automatic test_edge_cases();
    steady = 1'b1;
    push_sample(1'b0, '0);                                // nothing recorded yet
    push_sample(1'b1, '0);                                // commit with no timestamp
    push_sample(1'b1, 63'd1000);                          // first timed commit, no interval
    push_sample(1'b0, 63'd500);                           // time runs backward
    push_sample(1'b1, 63'd2000);                          // first interval
    push_sample(1'b1, 63'd1500);                          // commit earlier than the last
    push_sample(1'b1, 63'd1500);                          // commit at the same time
    push_sample(1'b1, 63'd1501);                          // one nanosecond interval
    push_sample(1'b0, 63'd1501 + 63'd2000000000);         // age exactly at the limit
    push_sample(1'b0, 63'd1502 + 63'd2000000000);         // age just past the limit
    push_sample(1'b1, 63'd1501 + (63'd1 << IVAL_W));      // interval saturates
    steady = 1'b0;
    push_sample(1'b1, {TIME_W{1'b1}});                    // jump to the latest time
    push_sample(1'b0, {TIME_W{1'b1}});
    push_sample(1'b0, 63'd12345);                         // far in the past
    push_sample(1'b1, '0);                                // zero commit clears has_last
    push_sample(1'b0, 63'd7);                             // stats invalid without a last commit
    push_sample(1'b1, 63'd7);                             // no interval after a zero commit
    push_sample(1'b1, 63'd7 + 63'd16666667);
    push_sample(1'b1, 63'd7 + 63'd33333334);
    push_sample(1'b0, 63'd7 + 63'd40000000);
  endtask

  // Both extremes of the recent window: zero accepts only an age of zero,
  // and the all-ones value accepts ages up to 2^32-1.
  task automatic test_recent_extremes();
    logic [TIME_W-1:0] base;
    base = 63'd5000000000;
    write_recent_window('0);
    push_sample(1'b1, base);
    push_sample(1'b1, base + 63'd10);
    push_sample(1'b0, base + 63'd10);
    push_sample(1'b0, base + 63'd11);
    push_sample(1'b0, base + 63'd9);
    write_recent_window({RECENT_W{1'b1}});
    push_sample(1'b0, base + 63'd10 + 63'hFFFF_FFFF);
    push_sample(1'b0, base + 63'd10 + 63'h1_0000_0000);
    push_sample(1'b1, base + 63'd20);
  endtask

  // Returns the next interval between commits: mostly frame-rate pacing,
  // with repeated values, tiny and very long intervals mixed in.
  function automatic logic [TIME_W-1:0] next_interval();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return TIME_W'($urandom_range(8000000, 40000000));
    if (pick < 68) return 63'd16666667;
    if (pick < 75) return 63'd33333333;
    if (pick < 85) return TIME_W'($urandom_range(1, 1000));
    if (pick < 95) return TIME_W'($urandom);
    return TIME_W'({$urandom, $urandom}) & 63'h000F_FFFF_FFFF_FFFF;
  endfunction

  // Long runs of well-formed pacing with random content, broken up by time
  // samples, backward time, zero commits and arbitrary timestamps. The
  // recent window is changed between blocks.
  task automatic test_random_pacing();
    logic [TIME_W-1:0] clock_ns;
    int                blk;
    int                k;
    int unsigned       pick;
    clock_ns = 63'd10000000000;
    for (blk = 0; blk < 8; blk++) begin
      case ($urandom_range(0, 4))
        0: write_recent_window('0);
        1: write_recent_window({RECENT_W{1'b1}});
        2: write_recent_window(RECENT_RESET);
        3: write_recent_window($urandom_range(1000, 100000000));
        default: write_recent_window($urandom);
      endcase
      steady = (blk % 3 == 2);
      for (k = 0; k < 50; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          clock_ns = clock_ns + next_interval();
          push_sample(1'b1, clock_ns);
        end else if (pick < 85) begin
          if ($urandom_range(0, 3) == 0) begin
            push_sample(1'b0, clock_ns + TIME_W'({$urandom_range(0, 3), $urandom}));
          end else begin
            push_sample(1'b0, clock_ns + TIME_W'($urandom_range(0, 50000000)));
          end
        end else if (pick < 90) begin
          clock_ns = clock_ns - TIME_W'($urandom_range(0, 1000));
          push_sample(1'b1, clock_ns);
        end else if (pick < 93) begin
          push_sample(1'b1, '0);
        end else if (pick < 97) begin
          push_sample(1'b0, TIME_W'({$urandom, $urandom}));
        end else begin
          clock_ns = TIME_W'({$urandom, $urandom});
          push_sample(1'b1, clock_ns);
        end
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    steady       = 1'b1;
    errors       = 0;

    ring_slot       = 0;
    ring_held       = 0;
    prev_commit_ns  = '0;
    commit_total    = '0;
    recent_limit_ns = RECENT_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_edge_cases();
    test_recent_extremes();
    test_random_pacing();

    drain_reports();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // A hung handshake ends the run here; a correct run needs a small fraction
  // of this time.
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
